[sv/signed_int_to_decimal_ascii_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the decimal text unit
// Shared immediate-style concurrent assertion wrappers, reset aware.
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define SIDA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the following cycle.
`define SIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[sv/sida_pkg.sv]
// ---------------------------------------------------------------------------
// sida_pkg
// Shared types, constants and the weight table of the decimal text unit.
// ---------------------------------------------------------------------------
package sida_pkg;

    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 6;
    localparam int POW_W    = 4;
    localparam int STEP_W   = 2;
    localparam int DIGIT_W  = 4;
    localparam int WEIGHT_W = 34;   // 8 * 10^9 needs 33 bits, keep one spare

    localparam logic [POW_W-1:0]   LAST_POW   = 4'd9;
    localparam logic [STEP_W-1:0]  FIRST_STEP = 2'd3;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 6'd48;  // '0'
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 6'd45;  // '-'

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic emit_sign;
        logic step;
        logic emit_digit;
        logic next_pow;
    } sida_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic negative;
        logic step_done;
        logic skip;
        logic final_pow;
    } sida_stat_t;

    // Power of ten for a digit position, scaled by 2^k for one binary step.
    function automatic logic [WEIGHT_W-1:0] step_weight(
        input logic [POW_W-1:0]  pow,
        input logic [STEP_W-1:0] k
    );
        logic [WEIGHT_W-1:0] base;
        case (pow)
            4'd0:    base = 34'd1000000000;
            4'd1:    base = 34'd100000000;
            4'd2:    base = 34'd10000000;
            4'd3:    base = 34'd1000000;
            4'd4:    base = 34'd100000;
            4'd5:    base = 34'd10000;
            4'd6:    base = 34'd1000;
            4'd7:    base = 34'd100;
            4'd8:    base = 34'd10;
            default: base = 34'd1;
        endcase
        return base << k;
    endfunction

endpackage

[sv/sida_datapath.sv]
// ---------------------------------------------------------------------------
// sida_datapath
// Magnitude register, shared compare-subtract unit and output word register.
// ---------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_unit_assert.svh"

module sida_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sida_pkg::sida_cmd_t           cmd,
    output sida_pkg::sida_stat_t          stat,
    input  logic [sida_pkg::VALUE_W-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sida_pkg::CHAR_W-1:0]   character,
    output logic                          last
);
    import sida_pkg::*;

    logic [VALUE_W-1:0]  mag_reg,     mag_next;
    logic [POW_W-1:0]    pow_reg,     pow_next;
    logic [STEP_W-1:0]   k_reg,       k_next;
    logic [DIGIT_W-1:0]  digit_reg,   digit_next;
    logic                started_reg, started_next;
    logic                neg_reg,     neg_next;
    logic                valid_reg,   valid_next;
    logic [CHAR_W-1:0]   char_reg,    char_next;
    logic                last_reg,    last_next;

    logic [WEIGHT_W-1:0] weight;
    logic [WEIGHT_W-1:0] mag_ext;
    logic [WEIGHT_W-1:0] diff;
    logic                fits;

    assign weight  = step_weight(pow_reg, k_reg);
    assign mag_ext = {{(WEIGHT_W-VALUE_W){1'b0}}, mag_reg};
    assign diff    = mag_ext - weight;
    assign fits    = (mag_ext >= weight);

    always_comb
    begin
        mag_next     = mag_reg;
        pow_next     = pow_reg;
        k_next       = k_reg;
        digit_next   = digit_reg;
        started_next = started_reg;
        neg_next     = neg_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        valid_next   = valid_reg && !out_ready;

        if (cmd.load)
        begin
            neg_next     = value[VALUE_W-1];
            mag_next     = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
            pow_next     = '0;
            k_next       = FIRST_STEP;
            digit_next   = '0;
            started_next = 1'b0;
        end
        if (cmd.step)
        begin
            // one binary weight per cycle: subtract 8w, 4w, 2w, w in turn
            if (fits)
            begin
                mag_next   = diff[VALUE_W-1:0];
                digit_next = digit_reg | (DIGIT_W'(1) << k_reg);
            end
            k_next = k_reg - STEP_W'(1);
        end
        if (cmd.emit_sign)
        begin
            valid_next = 1'b1;
            char_next  = CHAR_MINUS;
            last_next  = 1'b0;
        end
        if (cmd.emit_digit)
        begin
            valid_next   = 1'b1;
            char_next    = CHAR_ZERO + CHAR_W'(digit_reg);
            last_next    = (pow_reg == LAST_POW);
            started_next = 1'b1;
        end
        if (cmd.next_pow)
        begin
            pow_next   = pow_reg + POW_W'(1);
            k_next     = FIRST_STEP;
            digit_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        pow_reg     <= pow_next;
        k_reg       <= k_next;
        digit_reg   <= digit_next;
        started_reg <= started_next;
        neg_reg     <= neg_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign stat.out_free  = !valid_reg || out_ready;
    assign stat.negative  = neg_reg;
    assign stat.step_done = (k_reg == '0);
    assign stat.final_pow = (pow_reg == LAST_POW);
    assign stat.skip      = (digit_reg == '0) && !started_reg && (pow_reg != LAST_POW);

    assign out_valid = valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    // never overwrite a word that is still waiting
    `SIDA_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, cmd.emit_sign || cmd.emit_digit, !valid_reg || out_ready)
    // a finished digit is always a decimal digit
    `SIDA_ASSERT_NEXT(a_digit_range, clk, rst_n, cmd.step && (k_reg == '0), digit_reg <= 4'd9)
    // leading zeros are never emitted
    `SIDA_ASSERT_IMPLY(a_no_lead_zero, clk, rst_n, cmd.emit_digit, started_reg || (digit_reg != '0) || (pow_reg == LAST_POW))

endmodule

[sv/sida_ctrl.sv]
// ---------------------------------------------------------------------------
// sida_ctrl
// Sequencer: accept, optional sign, four steps and one put per power of ten.
// ---------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_unit_assert.svh"

module sida_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sida_pkg::sida_stat_t  stat,
    output sida_pkg::sida_cmd_t   cmd
);
    import sida_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SIGN,
        S_STEP,
        S_PUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                if (!stat.negative)
                begin
                    state_next = S_STEP;
                end
                else if (stat.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                if (stat.step_done)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (stat.skip)
                begin
                    cmd.next_pow = 1'b1;
                    state_next   = S_STEP;
                end
                else if (stat.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (stat.final_pow)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.next_pow = 1'b1;
                        state_next   = S_STEP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // an accepted word always starts a conversion
    `SIDA_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, state_reg == S_SIGN)
    // the final digit returns the sequencer to idle
    `SIDA_ASSERT_NEXT(a_final_idle, clk, rst_n, cmd.emit_digit && stat.final_pow, state_reg == S_IDLE)

endmodule

[sv/signed_int_to_decimal_ascii_unit.sv]
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Signed 32-bit integer to decimal ASCII text, one character per output word.
// ---------------------------------------------------------------------------
// Each input word carries a signed 32-bit value; the unit returns its decimal
// text as 1 to 11 output words, one ASCII character each ('-' or '0'..'9'),
// with last set on the final character. Zero gives a single '0', negative
// values lead with '-', and the most negative value gives "-2147483648".
// With no output stall, a number passes an accept slot and a sign slot,
// then for each of the ten powers of ten four compare-subtract steps and
// one put. The pace is set by the single 34-bit compare-subtract unit,
// which resolves one binary weight of a digit (8w, 4w, 2w, w) per cycle.
// A new word is accepted only once the previous number is fully handed to
// the output register; the output register lets the next digit proceed
// while the current character waits to be taken.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [sida_pkg::VALUE_W-1:0] value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sida_pkg::CHAR_W-1:0]   character,
    output logic                          last
);
    import sida_pkg::*;

    sida_cmd_t  cmd;
    sida_stat_t stat;

    // sequencer: walk the powers of ten, drop leading zeros, hold on stalls
    sida_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: magnitude, digit build-up and output word register
    sida_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

endmodule

[tb/sv/signed_int_to_decimal_ascii_unit_tb.sv]
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit_tb
// Self-checking bench for the signed integer to decimal text unit. Each
// number sent in is rendered to its expected characters by a local model of
// the digit loop, and every character the unit returns is checked in order
// against it. Both handshakes idle at random; directed cases cover zero, the
// signs, the extremes and the steps to two, three, ten and eleven characters.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sida_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int TAIL_CYCLES  = 80;       // a bit more than one full number
    localparam int MAX_TEXT     = 11;       // "-2147483648"

    // One expected character, with the number it came from for messages.
    typedef struct packed {
        logic [VALUE_W-1:0] source;
        logic [CHAR_W-1:0]  code;
        logic               is_last;
    } text_char_t;

    // DUT ports; every input starts at a known value.
    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic signed [VALUE_W-1:0] value     = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [CHAR_W-1:0]         character;
    logic                      last;

    // Characters still owed by the unit, oldest first.
    text_char_t expected_text [$];

    // Idle controls: when set, that side stops drawing random gaps.
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;

    int cycle_count    = 0;
    int mismatches     = 0;
    int numbers_sent   = 0;
    int negatives_sent = 0;
    int zeros_sent     = 0;
    int chars_checked  = 0;
    int longest_text   = 0;

    signed_int_to_decimal_ascii_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

    // 8 ns clock.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Watchdog: end the run if the unit hangs or a handshake never completes.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d characters still owed",
                     cycle_count, expected_text.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Expected text
    // -----------------------------------------------------------------------

    // 10^n as a 32-bit word, n from 0 to 9.
    function automatic logic [31:0] decade(input int n);
        logic [31:0] w;
        int          i;
        w = 32'd1;
        for (i = 0; i < n; i++)
            w = w * 32'd10;
        return w;
    endfunction

    // Render one number as the unit must: sign first when negative, then
    // digits by repeated subtraction from 10^9 down to 1. Leading zeros are
    // dropped, but the units digit always goes out, which gives zero its
    // single '0'. The magnitude is taken in unsigned 32-bit arithmetic, so
    // the most negative value needs no special path.
    function automatic void render_decimal(input logic [VALUE_W-1:0] bits);
        logic [CHAR_W-1:0] text [MAX_TEXT];
        logic [31:0]       mag;
        logic [31:0]       w;
        logic [3:0]        digit;
        bit                started;
        int                n;
        int                p;
        text_char_t        c;
        n       = 0;
        started = 1'b0;
        mag     = bits;
        if (bits[VALUE_W-1])
        begin
            text[n] = CHAR_MINUS;
            n++;
            mag = 32'd0 - bits;
            negatives_sent++;
        end
        if (bits == '0)
            zeros_sent++;
        for (p = 9; p >= 0; p--)
        begin
            w     = decade(p);
            digit = '0;
            while (mag >= w)
            begin
                mag   = mag - w;
                digit = digit + 4'd1;
            end
            if (digit != 4'd0 || p == 0)
                started = 1'b1;
            if (started)
            begin
                text[n] = CHAR_ZERO + digit;
                n++;
            end
        end
        for (p = 0; p < n; p++)
        begin
            c.source  = bits;
            c.code    = text[p];
            c.is_last = (p == n - 1);
            expected_text.push_back(c);
        end
        if (n > longest_text)
            longest_text = n;
    endfunction

    // -----------------------------------------------------------------------
    // Shared drivers
    // -----------------------------------------------------------------------

    task automatic note_failure(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR: %s", what);
    endtask

    // Send one number. Call at a rising edge; returns at the edge where the
    // word was taken. Valid is only dropped when a gap follows, so a
    // back-to-back word keeps it high with no glitch in between.
    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        render_decimal(v);
        numbers_sent++;
    endtask

    // Hold the sender until the unit has handed back every owed character.
    task automatic wait_text_drained();
        in_valid <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
    endtask

    // Random number, weighted so every text length shows up often: pick a
    // digit count, a value of that length and a sign. Some draws are raw
    // 32-bit words so every input bit toggles and the extremes can appear.
    function automatic logic [VALUE_W-1:0] rand_value();
        int unsigned ndig;
        int unsigned pick;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] v;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '0;
        if (pick <= 3)
            return $urandom;
        ndig = $urandom_range(1, 10);
        lo   = (ndig == 1) ? 32'd0 : decade(ndig - 1);
        hi   = (ndig == 10) ? 32'h7FFF_FFFF : decade(ndig) - 32'd1;
        v    = $urandom_range(hi, lo);
        if ($urandom_range(0, 1) == 1)
            v = 32'd0 - v;
        return v;
    endfunction

    // -----------------------------------------------------------------------
    // Result checker: draw a stall per character, take it, compare it with
    // the oldest expectation field by field.
    // -----------------------------------------------------------------------
    initial
    begin : char_checker
        text_char_t want;
        int         gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = rx_quiet ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            chars_checked++;
            if (expected_text.size() == 0)
            begin
                note_failure($sformatf("unexpected character %0d last=%0b",
                                       character, last));
            end
            else
            begin
                want = expected_text.pop_front();
                if (character !== want.code)
                    note_failure($sformatf("value %0d: character exp %0d got %0d",
                                           $signed(want.source), want.code, character));
                if (last !== want.is_last)
                    note_failure($sformatf("value %0d: last exp %0b got %0b",
                                           $signed(want.source), want.is_last, last));
            end
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Zero, unit values of both signs, and both ends of the range, sent
    // back to back with the receiver always ready.
    task automatic test_sign_and_zero();
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        send_value(32'sd0);
        send_value(32'sd1);
        send_value(-32'sd1);
        send_value(32'sd2147483647);
        send_value(32'h8000_0000);     // most negative value
        send_value(-32'sd2147483647);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // The points where one more digit appears: one to two, two to three, nine to ten.
    task automatic test_digit_boundaries();
        send_value(32'sd9);
        send_value(32'sd10);
        send_value(32'sd99);
        send_value(32'sd100);
        send_value(32'sd999999999);
        send_value(32'sd1000000000);
        send_value(-32'sd9);
        send_value(-32'sd10);
        send_value(-32'sd999999999);
        send_value(-32'sd1000000000);
    endtask

    // Inner zeros, every digit value and alternating bit patterns.
    task automatic test_mixed_patterns();
        send_value(32'sd1234567890);
        send_value(-32'sd987654321);
        send_value(32'h5555_5555);
        send_value(32'hAAAA_AAAA);
        send_value(32'sd1000000001);
        send_value(-32'sd100000);
    endtask

    // Stop the sender until the text is fully out, twice, then resume.
    task automatic test_drain_pause();
        int i;
        for (i = 0; i < 3; i++)
            send_value(rand_value());
        wait_text_drained();
        for (i = 0; i < 3; i++)
            send_value(rand_value());
        wait_text_drained();
    endtask

    // Bulk random numbers; switch idling styles every 40 words and drain
    // now and then so gaps land on every phase of the digit loop.
    task automatic test_random_values(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            if (i % 85 == 84)
                wait_text_drained();
            send_value(rand_value());
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_sign_and_zero();
        test_digit_boundaries();
        test_mixed_patterns();
        test_drain_pause();
        test_random_values(340);

        // Let the last text come out, then watch for stray characters.
        wait_text_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Rendered %0d numbers (%0d negative, %0d zero), longest text %0d chars",
                 numbers_sent, negatives_sent, zeros_sent, longest_text);
        $display("Checked %0d characters, %0d mismatches", chars_checked, mismatches);
        if (mismatches == 0 && expected_text.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
